// File: rtl/mdu_pkg.sv
// Package for the multiply/divide register unit.
// Holds field widths, register offsets, the sequencer state type and unit status structs.
// No dependencies.
package mdu_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int WORD_WIDTH   = 16;
   localparam int OFFSET_WIDTH = 5;
   localparam int MUL_STEPS    = 8;
   localparam int DIV_STEPS    = 16;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_STEPS);
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   // Register offsets from the block base
   localparam logic [OFFSET_WIDTH-1:0] OFS_MULTIPLICAND = 5'd2;
   localparam logic [OFFSET_WIDTH-1:0] OFS_MULTIPLIER   = 5'd3;
   localparam logic [OFFSET_WIDTH-1:0] OFS_DIVIDEND_LO  = 5'd4;
   localparam logic [OFFSET_WIDTH-1:0] OFS_DIVIDEND_HI  = 5'd5;
   localparam logic [OFFSET_WIDTH-1:0] OFS_DIVISOR      = 5'd6;
   localparam logic [OFFSET_WIDTH-1:0] OFS_QUOT_LO      = 5'd20;
   localparam logic [OFFSET_WIDTH-1:0] OFS_QUOT_HI      = 5'd21;
   localparam logic [OFFSET_WIDTH-1:0] OFS_PROD_LO      = 5'd22;
   localparam logic [OFFSET_WIDTH-1:0] OFS_PROD_HI      = 5'd23;

   // Bus access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] BYTE_ONES = 8'hff;
   localparam logic [WORD_WIDTH-1:0] WORD_ONES = 16'hffff;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [WORD_WIDTH-1:0] product;
   } mul_status_type;

   typedef struct packed {
      logic                  done;
      logic [WORD_WIDTH-1:0] quotient;
      logic [BYTE_WIDTH-1:0] remainder;
   } div_status_type;

endpackage

// File: rtl/mdu_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on mdu_pkg for field widths.
interface mdu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [mdu_pkg::OFFSET_WIDTH-1:0]     reg_offset;
   logic [mdu_pkg::BYTE_WIDTH-1:0]       write_data;
   logic [mdu_pkg::BYTE_WIDTH-1:0]       open_bus_value;

   modport source (output valid, output operation, output reg_offset,
                   output write_data, output open_bus_value, input ready);
   modport sink   (input valid, input operation, input reg_offset,
                   input write_data, input open_bus_value, output ready);
endinterface

interface mdu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mdu_pkg::BYTE_WIDTH-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

// File: rtl/mdu_mul.sv
// Bit-serial 8x8 unsigned multiplier, one multiplier bit per cycle (shift-add).
// Depends on mdu_pkg.
module mdu_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mdu_pkg::BYTE_WIDTH-1:0]     multiplicand,
   input  logic [mdu_pkg::BYTE_WIDTH-1:0]     multiplier,
   output mdu_pkg::mul_status_type            status
);
   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [mdu_pkg::MUL_CNT_WIDTH-1:0]    count_ff, count_in;
   logic [mdu_pkg::BYTE_WIDTH-1:0]       mcand_ff, mcand_in;
   // upper half: partial sum, lower half: remaining multiplier bits
   logic [mdu_pkg::WORD_WIDTH-1:0]       acc_ff, acc_in;
   logic [mdu_pkg::BYTE_WIDTH:0]         sum;
   logic                                 last;

   assign last = (count_ff == mdu_pkg::MUL_CNT_WIDTH'(mdu_pkg::MUL_STEPS - 1));

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      done_in  = busy_ff && last;
      sum      = {1'b0, acc_ff[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH]}
               + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         mcand_in = multiplicand;
         acc_in   = {{mdu_pkg::BYTE_WIDTH{1'b0}}, multiplier};
      end else if (busy_ff) begin
         acc_in   = {sum, acc_ff[mdu_pkg::BYTE_WIDTH-1:1]};
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign status.done    = done_ff;
   assign status.product = acc_ff;

endmodule

// File: rtl/mdu_div.sv
// Bit-serial restoring divider, 16-bit dividend by 8-bit nonzero divisor,
// one quotient bit per cycle. Depends on mdu_pkg.
module mdu_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mdu_pkg::WORD_WIDTH-1:0]     dividend,
   input  logic [mdu_pkg::BYTE_WIDTH-1:0]     divisor,
   output mdu_pkg::div_status_type            status
);
   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [mdu_pkg::DIV_CNT_WIDTH-1:0]    count_ff, count_in;
   logic [mdu_pkg::BYTE_WIDTH-1:0]       dvsr_ff, dvsr_in;
   logic [mdu_pkg::BYTE_WIDTH-1:0]       rem_ff, rem_in;
   // dividend bits shift out the top, quotient bits shift in the bottom
   logic [mdu_pkg::WORD_WIDTH-1:0]       quo_ff, quo_in;
   logic [mdu_pkg::BYTE_WIDTH:0]         shifted;
   logic [mdu_pkg::BYTE_WIDTH+1:0]       diff;
   logic                                 fits;
   logic                                 last;

   assign last    = (count_ff == mdu_pkg::DIV_CNT_WIDTH'(mdu_pkg::DIV_STEPS - 1));
   assign shifted = {rem_ff, quo_ff[mdu_pkg::WORD_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
   assign fits    = !diff[mdu_pkg::BYTE_WIDTH+1];

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      dvsr_in  = dvsr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      done_in  = busy_ff && last;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvsr_in  = divisor;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[mdu_pkg::BYTE_WIDTH-1:0] : shifted[mdu_pkg::BYTE_WIDTH-1:0];
         quo_in   = {quo_ff[mdu_pkg::WORD_WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

// File: rtl/multiply_divide_register_unit.sv
// Top level of the register-mapped multiply/divide unit.
// Depends on mdu_pkg, mdu_if (channels), mdu_mul and mdu_div.
//
// Usage:
//   req: one bus access per request (operation 0 read / 1 write, reg_offset,
//        write_data, open_bus_value). rsp: one byte per request, read_data,
//        zero for writes, open_bus_value for unmapped or write-only reads.
//   Writes: 2 multiplicand, 3 multiplier (starts multiply), 4/5 dividend
//   low/high, 6 divisor (starts divide). Reads: 20/21 quotient, 22/23
//   product or remainder.
//   The response is registered and appears in the cycle after the request is taken.
//   Reads and plain writes leave the block ready for the next request
//   unless the response stalls. A multiplier write holds off the next
//   request for the 8 shift-add steps in mdu_mul plus the result load; a
//   divisor write for the 16 restoring steps in mdu_div plus the load. A
//   zero divisor is resolved at once: quotient 0xFFFF, remainder the dividend.
//   Reset: multiplicand and dividend start as all ones, quotient and
//   product/remainder as zero; no response pending.
//   Stall: the response register holds while rsp.ready is low; a new
//   request is taken in the cycle the pending response drains.
module multiply_divide_register_unit (
   input  logic      clock,
   input  logic      reset,
   mdu_req_if.sink   req,
   mdu_rsp_if.source rsp
);
   mdu_pkg::state_type                state_ff, state_in;

   // architectural registers
   logic [mdu_pkg::BYTE_WIDTH-1:0]    multiplicand_ff, multiplicand_in;
   logic [mdu_pkg::WORD_WIDTH-1:0]    dividend_ff, dividend_in;
   logic [mdu_pkg::WORD_WIDTH-1:0]    quotient_ff, quotient_in;
   logic [mdu_pkg::WORD_WIDTH-1:0]    prodrem_ff, prodrem_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mdu_pkg::BYTE_WIDTH-1:0]    rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              is_write;
   logic                              mul_start;
   logic                              div_start;
   mdu_pkg::mul_status_type           mul_sts;
   mdu_pkg::div_status_type           div_sts;

   // only take a request when no arithmetic is in flight and the
   // response slot is free or draining this cycle
   assign req.ready = (state_ff == mdu_pkg::ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign is_write  = (req.operation == mdu_pkg::OP_WRITE);

   assign mul_start = accept && is_write && (req.reg_offset == mdu_pkg::OFS_MULTIPLIER);
   assign div_start = accept && is_write && (req.reg_offset == mdu_pkg::OFS_DIVISOR)
                      && (req.write_data != '0);

   mdu_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (multiplicand_ff),
      .multiplier   (req.write_data),
      .status       (mul_sts)
   );

   mdu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (req.write_data),
      .status   (div_sts)
   );

   always_comb begin
      state_in        = state_ff;
      multiplicand_in = multiplicand_ff;
      dividend_in     = dividend_ff;
      quotient_in     = quotient_ff;
      prodrem_in      = prodrem_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_data_in     = rsp_data_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         if (is_write) begin
            rsp_data_in = '0;
            case (req.reg_offset)
               mdu_pkg::OFS_MULTIPLICAND: multiplicand_in = req.write_data;
               mdu_pkg::OFS_MULTIPLIER:   state_in = mdu_pkg::ST_MUL;
               mdu_pkg::OFS_DIVIDEND_LO:
                  dividend_in = {dividend_ff[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH],
                                 req.write_data};
               mdu_pkg::OFS_DIVIDEND_HI:
                  dividend_in = {req.write_data, dividend_ff[mdu_pkg::BYTE_WIDTH-1:0]};
               mdu_pkg::OFS_DIVISOR: begin
                  if (req.write_data == '0) begin
                     // divide by zero: all-ones quotient, dividend as remainder
                     quotient_in = mdu_pkg::WORD_ONES;
                     prodrem_in  = dividend_ff;
                  end else begin
                     state_in = mdu_pkg::ST_DIV;
                  end
               end
               default: ;
            endcase
         end else begin
            case (req.reg_offset)
               mdu_pkg::OFS_QUOT_LO: rsp_data_in = quotient_ff[mdu_pkg::BYTE_WIDTH-1:0];
               mdu_pkg::OFS_QUOT_HI:
                  rsp_data_in = quotient_ff[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH];
               mdu_pkg::OFS_PROD_LO: rsp_data_in = prodrem_ff[mdu_pkg::BYTE_WIDTH-1:0];
               mdu_pkg::OFS_PROD_HI:
                  rsp_data_in = prodrem_ff[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH];
               default:              rsp_data_in = req.open_bus_value;
            endcase
         end
      end

      case (state_ff)
         mdu_pkg::ST_MUL: begin
            if (mul_sts.done) begin
               prodrem_in = mul_sts.product;
               state_in   = mdu_pkg::ST_IDLE;
            end
         end
         mdu_pkg::ST_DIV: begin
            if (div_sts.done) begin
               quotient_in = div_sts.quotient;
               prodrem_in  = {{(mdu_pkg::WORD_WIDTH-mdu_pkg::BYTE_WIDTH){1'b0}},
                              div_sts.remainder};
               state_in    = mdu_pkg::ST_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mdu_pkg::ST_IDLE;
         multiplicand_ff <= mdu_pkg::BYTE_ONES;
         dividend_ff     <= mdu_pkg::WORD_ONES;
         quotient_ff     <= '0;
         prodrem_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         multiplicand_ff <= multiplicand_in;
         dividend_ff     <= dividend_in;
         quotient_ff     <= quotient_in;
         prodrem_ff      <= prodrem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == mdu_pkg::ST_IDLE))
      else $error("request taken while arithmetic in flight");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == mdu_pkg::ST_MUL))
      else $error("multiply finished outside multiply state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == mdu_pkg::ST_DIV))
      else $error("divide finished outside divide state");

   a_mul_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |=> (state_ff == mdu_pkg::ST_MUL))
      else $error("multiplier write did not start a multiply");

   a_no_double_start: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiply and divide started together");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for multiply_divide_register_unit.
// Needs mdu_pkg and the mdu_req_if / mdu_rsp_if interfaces; drives bus requests,
// tracks register state on the side and checks every read_data byte in order.
module tb_top;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int PHASE_LEN     = 450;      // requests per idling phase
   localparam int HOLD_FIRST_AT = 200;      // request count that starts a long rsp stall
   localparam int HOLD_SPACING  = 900;
   localparam int HOLD_CYCLES   = 250;
   localparam int DRAIN_AT      = 700;      // request index the sender waits in front of
   localparam int TAIL_CYCLES   = 24;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SHOWN_ERRORS  = 10;

   // One bus access as the sender offers it; drain_first makes the sender wait
   // until every outstanding read_data byte has come back.
   typedef struct {
      logic                             operation;
      logic [mdu_pkg::OFFSET_WIDTH-1:0] reg_offset;
      logic [mdu_pkg::BYTE_WIDTH-1:0]   write_data;
      logic [mdu_pkg::BYTE_WIDTH-1:0]   open_bus_value;
      bit                               drain_first;
   } bus_access_type;

   logic clock;
   logic reset;

   mdu_req_if req_ch ();
   mdu_rsp_if rsp_ch ();

   multiply_divide_register_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Side copy of the register file
   logic [mdu_pkg::BYTE_WIDTH-1:0] factor_a;
   logic [mdu_pkg::BYTE_WIDTH-1:0] factor_b;
   logic [mdu_pkg::WORD_WIDTH-1:0] numerator;
   logic [mdu_pkg::BYTE_WIDTH-1:0] denominator;
   logic [mdu_pkg::WORD_WIDTH-1:0] quo_word;
   logic [mdu_pkg::WORD_WIDTH-1:0] prod_rem_word;

   bus_access_type                 pending_accesses[$];   // not yet offered
   logic [mdu_pkg::BYTE_WIDTH-1:0] read_bytes_due[$];     // expected read_data, oldest first
   bus_access_type                 offered;

   int  total_accesses;
   int  taken_count;
   int  mismatches;
   int  cycle_count;
   int  hold_left;
   int  next_hold_at;
   bit  req_taken;        // request accepted at the last rising edge
   int  send_idle_pct;
   int  recv_idle_pct;

   // ---------------------------------------------------------------
   // Register behavior: apply one access, return the byte it reads
   // ---------------------------------------------------------------
   function automatic logic [mdu_pkg::BYTE_WIDTH-1:0] bus_access_byte(
         input bus_access_type acc);
      logic [mdu_pkg::BYTE_WIDTH-1:0] rd;
      rd = '0;
      if (acc.operation == mdu_pkg::OP_WRITE) begin
         case (acc.reg_offset)
            mdu_pkg::OFS_MULTIPLICAND: factor_a = acc.write_data;
            mdu_pkg::OFS_MULTIPLIER: begin
               factor_b      = acc.write_data;
               prod_rem_word = mdu_pkg::WORD_WIDTH'(factor_a)
                             * mdu_pkg::WORD_WIDTH'(factor_b);
            end
            mdu_pkg::OFS_DIVIDEND_LO:
               numerator[mdu_pkg::BYTE_WIDTH-1:0] = acc.write_data;
            mdu_pkg::OFS_DIVIDEND_HI:
               numerator[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH] = acc.write_data;
            mdu_pkg::OFS_DIVISOR: begin
               denominator = acc.write_data;
               if (denominator == '0) begin
                  // divide by zero: all-ones quotient, dividend kept as remainder
                  quo_word      = mdu_pkg::WORD_ONES;
                  prod_rem_word = numerator;
               end else begin
                  quo_word      = numerator / mdu_pkg::WORD_WIDTH'(denominator);
                  prod_rem_word = numerator % mdu_pkg::WORD_WIDTH'(denominator);
               end
            end
            default: ;   // read-only or unmapped: write dropped
         endcase
      end else begin
         case (acc.reg_offset)
            mdu_pkg::OFS_QUOT_LO: rd = quo_word[mdu_pkg::BYTE_WIDTH-1:0];
            mdu_pkg::OFS_QUOT_HI: rd = quo_word[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH];
            mdu_pkg::OFS_PROD_LO: rd = prod_rem_word[mdu_pkg::BYTE_WIDTH-1:0];
            mdu_pkg::OFS_PROD_HI:
               rd = prod_rem_word[mdu_pkg::WORD_WIDTH-1:mdu_pkg::BYTE_WIDTH];
            default:              rd = acc.open_bus_value;   // open bus
         endcase
      end
      return rd;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [mdu_pkg::BYTE_WIDTH-1:0] pick_byte();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return '0;
      if (sel == 1) return mdu_pkg::BYTE_ONES;
      return mdu_pkg::BYTE_WIDTH'($urandom);
   endfunction

   function automatic void add_access(input logic op,
                                      input logic [mdu_pkg::OFFSET_WIDTH-1:0] ofs,
                                      input logic [mdu_pkg::BYTE_WIDTH-1:0] data,
                                      input logic [mdu_pkg::BYTE_WIDTH-1:0] open_bus);
      bus_access_type acc;
      acc.operation      = op;
      acc.reg_offset     = ofs;
      acc.write_data     = data;
      acc.open_bus_value = open_bus;
      acc.drain_first    = 1'b0;
      pending_accesses.push_back(acc);
   endfunction

   function automatic void add_read(input logic [mdu_pkg::OFFSET_WIDTH-1:0] ofs);
      add_access(mdu_pkg::OP_READ, ofs, mdu_pkg::BYTE_WIDTH'($urandom),
                 mdu_pkg::BYTE_WIDTH'($urandom));
   endfunction

   function automatic void add_write(input logic [mdu_pkg::OFFSET_WIDTH-1:0] ofs,
                                     input logic [mdu_pkg::BYTE_WIDTH-1:0] data);
      add_access(mdu_pkg::OP_WRITE, ofs, data, mdu_pkg::BYTE_WIDTH'($urandom));
   endfunction

   // Directed opening: reset values, open bus, both arithmetic extremes,
   // zero divisor, byte-only dividend writes, dropped writes.
   function automatic void build_directed();
      add_read(mdu_pkg::OFS_QUOT_LO);
      add_read(mdu_pkg::OFS_QUOT_HI);
      add_read(mdu_pkg::OFS_PROD_LO);
      add_read(mdu_pkg::OFS_PROD_HI);
      add_access(mdu_pkg::OP_READ, 5'd0, mdu_pkg::BYTE_ONES, '0);
      add_access(mdu_pkg::OP_READ, 5'd31, '0, mdu_pkg::BYTE_ONES);
      // write-only reg reads open bus
      add_access(mdu_pkg::OP_READ, mdu_pkg::OFS_DIVISOR, 8'h5a, 8'ha5);
      add_write(mdu_pkg::OFS_MULTIPLIER, mdu_pkg::BYTE_ONES);   // 0xff * 0xff
      add_read(mdu_pkg::OFS_PROD_LO);
      add_read(mdu_pkg::OFS_PROD_HI);
      add_write(mdu_pkg::OFS_MULTIPLICAND, '0);                 // no multiply started
      add_read(mdu_pkg::OFS_PROD_HI);
      add_write(mdu_pkg::OFS_DIVISOR, '0);                      // divide by zero on reset dividend
      add_read(mdu_pkg::OFS_QUOT_LO);
      add_read(mdu_pkg::OFS_QUOT_HI);
      add_read(mdu_pkg::OFS_PROD_LO);
      add_read(mdu_pkg::OFS_PROD_HI);
      add_write(mdu_pkg::OFS_DIVISOR, 8'h01);
      add_read(mdu_pkg::OFS_QUOT_HI);
      add_write(mdu_pkg::OFS_DIVIDEND_LO, '0);                  // half writes only touch one byte
      add_write(mdu_pkg::OFS_DIVIDEND_HI, '0);
      add_write(mdu_pkg::OFS_DIVISOR, mdu_pkg::BYTE_ONES);
      add_read(mdu_pkg::OFS_QUOT_LO);
      add_write(mdu_pkg::OFS_QUOT_LO, 8'haa);                   // read-only target, dropped
      add_write(5'd31, mdu_pkg::BYTE_ONES);                     // unmapped, dropped
      add_read(mdu_pkg::OFS_QUOT_LO);
   endfunction

   // Random part: mostly complete multiply / divide sequences, some noise.
   function automatic void build_random(input int target);
      int kind;
      int n;
      while (pending_accesses.size() < target) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            if ($urandom_range(3) != 0) add_write(mdu_pkg::OFS_MULTIPLICAND, pick_byte());
            add_write(mdu_pkg::OFS_MULTIPLIER, pick_byte());
            if ($urandom_range(1)) begin
               add_read(mdu_pkg::OFS_PROD_LO);
               add_read(mdu_pkg::OFS_PROD_HI);
            end else begin
               add_read(mdu_pkg::OFS_PROD_HI);
               add_read(mdu_pkg::OFS_PROD_LO);
            end
         end else if (kind < 8) begin
            if ($urandom_range(3) != 0) add_write(mdu_pkg::OFS_DIVIDEND_LO, pick_byte());
            if ($urandom_range(3) != 0) add_write(mdu_pkg::OFS_DIVIDEND_HI, pick_byte());
            add_write(mdu_pkg::OFS_DIVISOR, ($urandom_range(7) == 0) ? '0 : pick_byte());
            if ($urandom_range(3) != 0) add_read(mdu_pkg::OFS_QUOT_LO);
            if ($urandom_range(3) != 0) add_read(mdu_pkg::OFS_QUOT_HI);
            if ($urandom_range(3) != 0) add_read(mdu_pkg::OFS_PROD_LO);
            if ($urandom_range(3) != 0) add_read(mdu_pkg::OFS_PROD_HI);
         end else begin
            // noise: any kind, any offset, any data
            n = $urandom_range(1, 4);
            repeat (n) add_access(1'($urandom), mdu_pkg::OFFSET_WIDTH'($urandom),
                                  mdu_pkg::BYTE_WIDTH'($urandom),
                                  mdu_pkg::BYTE_WIDTH'($urandom));
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // Clock and cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Idle rates follow the number of accepted requests: sender rarely idle
   // and receiver often, then the reverse, then no idling at all.
   always_comb begin
      if (taken_count < PHASE_LEN) begin
         send_idle_pct = 7;
         recv_idle_pct = 65;
      end else if (taken_count < 2 * PHASE_LEN) begin
         send_idle_pct = 65;
         recv_idle_pct = 7;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // ---------------------------------------------------------------
   // Request driver: changes on the falling edge, holds a request until taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         req_ch.valid <= 1'b1;   // still waiting for ready
      end else if (pending_accesses.size() != 0
                   && !(pending_accesses[0].drain_first && read_bytes_due.size() != 0)
                   && $urandom_range(99) >= send_idle_pct) begin
         offered                = pending_accesses.pop_front();
         req_ch.valid          <= 1'b1;
         req_ch.operation      <= offered.operation;
         req_ch.reg_offset     <= offered.reg_offset;
         req_ch.write_data     <= offered.write_data;
         req_ch.open_bus_value <= offered.open_bus_value;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Response ready: random stalls plus long hold-offs that back the
   // block up until it stops taking requests
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         next_hold_at <= HOLD_FIRST_AT;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (taken_count >= next_hold_at) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // Monitor: sample both handshakes on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      bus_access_type                 seen;
      logic [mdu_pkg::BYTE_WIDTH-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.operation      = req_ch.operation;
            seen.reg_offset     = req_ch.reg_offset;
            seen.write_data     = req_ch.write_data;
            seen.open_bus_value = req_ch.open_bus_value;
            seen.drain_first    = 1'b0;
            read_bytes_due.push_back(bus_access_byte(seen));
            taken_count <= taken_count + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (read_bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("rsp with no request outstanding: read_data=%h", rsp_ch.read_data);
            end else begin
               want = read_bytes_due.pop_front();
               if (rsp_ch.read_data !== want) begin
                  mismatches++;
                  if (mismatches <= SHOWN_ERRORS)
                     $display("read_data: expected %h, got %h", want, rsp_ch.read_data);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      // every block input known from time zero
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.operation      = mdu_pkg::OP_READ;
      req_ch.reg_offset     = '0;
      req_ch.write_data     = '0;
      req_ch.open_bus_value = '0;
      rsp_ch.ready          = 1'b0;
      taken_count           = 0;
      mismatches            = 0;
      cycle_count           = 0;
      req_taken             = 1'b0;

      // register state after reset
      factor_a      = mdu_pkg::BYTE_ONES;
      factor_b      = mdu_pkg::BYTE_ONES;
      numerator     = mdu_pkg::WORD_ONES;
      denominator   = mdu_pkg::BYTE_ONES;
      quo_word      = '0;
      prod_rem_word = '0;

      build_directed();
      build_random(pending_accesses.size() + RANDOM_ITEMS);
      pending_accesses[DRAIN_AT].drain_first = 1'b1;   // one full drain mid-run
      total_accesses = pending_accesses.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (taken_count == total_accesses);
      while (read_bytes_due.size() != 0) @(posedge clock);
      // let any stray response show up before judging
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
